// ----- rtl/prs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, constants and round functions for the PRESENT-80 encryptor.
// ----------------------------------------------------------------------------
package prs_pkg;

	localparam int ROUNDS    = 31;
	localparam int BLOCK_W   = 64;
	localparam int KEY_W     = 80;
	localparam int KEY_LO_W  = 16;
	localparam int RC_W      = 5;

	typedef enum logic [0:0] {
		CFG_KEY_UPPER = 1'b0,
		CFG_KEY_LOWER = 1'b1
	} cfg_index_t;

	// One stage of the round chain: valid flag, data and the key for that round.
	typedef struct packed {
		logic               valid;
		logic [BLOCK_W-1:0] data;
		logic [KEY_W-1:0]   key;
	} prs_stage_t;

	function automatic logic [3:0] sbox(input logic [3:0] x);
		logic [3:0] y;
		unique case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			default: y = 4'h2;
		endcase
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] x);
		logic [BLOCK_W-1:0] y;
		for (int n = 0; n < BLOCK_W / 4; n++) begin
			y[4*n +: 4] = sbox(x[4*n +: 4]);
		end
		return y;
	endfunction

	// Bit b moves to 16*b mod 63; bit 63 stays.
	function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
		logic [BLOCK_W-1:0] y;
		for (int b = 0; b < BLOCK_W; b++) begin
			if (b == BLOCK_W - 1) begin
				y[b] = x[b];
			end else begin
				y[(16 * b) % (BLOCK_W - 1)] = x[b];
			end
		end
		return y;
	endfunction

	// Rotate left by 61, top nibble through the S-box, counter into bits 19..15.
	function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
	                                             input logic [RC_W-1:0]  rc);
		logic [KEY_W-1:0] r;
		r = {k[18:0], k[KEY_W-1:19]};
		r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
		r[19:15] = r[19:15] ^ rc;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/prs_round_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs_round_cell
// One PRESENT round with its key update, registered, with local flow control.
// The last cell also applies the final key whitening.
// ----------------------------------------------------------------------------
module prs_round_cell
	import prs_pkg::*;
#(
	parameter int ROUND = 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire prs_stage_t prev,
	output logic            ready,
	output prs_stage_t      nxt,
	input  wire logic       next_ready
);

	localparam logic [RC_W-1:0] RC   = ROUND[RC_W-1:0];
	localparam bit              LAST = (ROUND == ROUNDS);

	logic               valid_q;
	logic [BLOCK_W-1:0] data_q;
	logic [KEY_W-1:0]   key_q;
	logic               take;
	logic [BLOCK_W-1:0] round_out;
	logic [KEY_W-1:0]   key_out;

	// Accept when empty or when the neighbor drains this cell in the same cycle.
	assign ready = !valid_q || next_ready;
	assign take  = prev.valid && ready;

	always_comb begin
		key_out   = next_key(prev.key, RC);
		round_out = perm_layer(sub_layer(prev.data ^ prev.key[KEY_W-1 -: BLOCK_W]));
		if (LAST) begin
			round_out = round_out ^ key_out[KEY_W-1 -: BLOCK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= round_out;
			key_q  <= key_out;
		end
	end

	assign nxt.valid = valid_q;
	assign nxt.data  = data_q;
	assign nxt.key   = key_q;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !next_ready) |=> (valid_q && $stable(data_q) && $stable(key_q)))
		else $error("round cell lost or changed a held block");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_q)
		else $error("round cell dropped a transfer");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && next_ready && !prev.valid) |=> !valid_q)
		else $error("round cell repeated a block");
`endif

endmodule
`default_nettype wire

// ----- rtl/present80_block_encrypt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// present80_block_encrypt
// PRESENT-80 encryption as a chain of 31 registered round cells.
//
//   channel  handshake                direction  payload
//   input    in_valid / in_stall      in         plain_block[63:0]
//   output   out_valid / out_stall    out        cipher_block[63:0]
//   config   cfg_wr_en                in         cfg_index, cfg_data[63:0]
//
// One block per cycle is taken while in_stall is low; each block passes
// through the round cells in order, one register per round cell.
// Reset clears the cell valid flags and sets both key registers to zero.
// out_stall holds the last cell; cells behind it keep filling up empty
// slots, so in_stall rises only once the whole chain is full.
// ----------------------------------------------------------------------------
module present80_block_encrypt
	import prs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [BLOCK_W-1:0] plain_block,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [BLOCK_W-1:0]      cipher_block,
	input  wire logic               cfg_wr_en,
	input  wire cfg_index_t         cfg_index,
	input  wire logic [BLOCK_W-1:0] cfg_data
);

	logic [BLOCK_W-1:0]  key_upper_q;
	logic [KEY_LO_W-1:0] key_lower_q;
	prs_stage_t          st [0:ROUNDS];
	logic                rdy [0:ROUNDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_KEY_UPPER: key_upper_q <= cfg_data;
				CFG_KEY_LOWER: key_lower_q <= cfg_data[KEY_LO_W-1:0];
				default: ;
			endcase
		end
	end

	assign st[0].valid = in_valid;
	assign st[0].data  = plain_block;
	assign st[0].key   = {key_upper_q, key_lower_q};
	assign in_stall    = !rdy[0];
	assign rdy[ROUNDS] = !out_stall;

	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		prs_round_cell #(
			.ROUND (i + 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev       (st[i]),
			.ready      (rdy[i]),
			.nxt        (st[i+1]),
			.next_ready (rdy[i+1])
		);
	end

	assign out_valid    = st[ROUNDS].valid;
	assign cipher_block = st[ROUNDS].data;

endmodule
`default_nettype wire
